@@ hdl/lpps_pkg.sv @@
package lpps_pkg;

    // sample format
    localparam int SAMPLE_BITS = 12;
    localparam int SUM_W       = SAMPLE_BITS + 2;        // plain sum of four samples
    localparam int WSUM_W      = SUM_W + 1;              // signed weighted sum
    localparam int POS_FRAC    = 8;                      // position in 1/256 units
    localparam int Q_BITS      = 10;                     // |position| <= 768
    localparam int DVD_W       = SUM_W + POS_FRAC;       // dividend = |wsum| * 256
    localparam int DVS_W       = SUM_W + Q_BITS - 1;     // divisor aligned to top quotient bit
    localparam int CNT_W       = $clog2(Q_BITS);

    // control loop widths
    localparam int ERR_W   = 11;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int GAIN_W  = 10;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int ACC_W   = PROD_W + 2;
    localparam int CORR_W  = ACC_W - POS_FRAC;
    localparam int DSUM_W  = CORR_W + 1;
    localparam int DRIVE_W = 12;

    // config register widths
    localparam int SPEED_W = 12;
    localparam int LIMIT_W = 10;
    localparam int BIAS_W  = 8;
    localparam int OFFS_W  = 10;
    localparam int THR_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_BIAS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_OFFSET = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_THR    = 3'd7;

    // register reset values
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN   = 10'd128;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN  = 10'd0;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN  = 10'd102;
    localparam logic [SPEED_W-1:0] RST_BASE_SPEED  = 12'd26;
    localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT = 10'd77;
    localparam logic [BIAS_W-1:0]  RST_TURN_BIAS   = 8'd77;
    localparam logic [OFFS_W-1:0]  RST_LOST_OFFSET = 10'd38;
    localparam logic [THR_W-1:0]   RST_DARK_THR    = 12'd1638;

    // drive limits
    localparam int DRIVE_MIN  = 256;
    localparam int DRIVE_MAX  = 2560;
    localparam int BIAS_SPLIT = 13;
    localparam int OUT_MIN    = DRIVE_MIN - 255;
    localparam int OUT_MAX    = DRIVE_MAX + 255;
    localparam int ROUND_HALF = 128;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_a;
        logic [SAMPLE_BITS-1:0] sample_b;
        logic [SAMPLE_BITS-1:0] sample_c;
        logic [SAMPLE_BITS-1:0] sample_d;
    } t_in_item;

    typedef struct packed {
        logic [DRIVE_W-1:0] left_drive;
        logic [DRIVE_W-1:0] right_drive;
    } t_out_item;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic en;
        logic clear;
    } t_mac_ctrl;

endpackage

@@ hdl/lpps_div.sv @@
module lpps_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpps_pkg::t_div_ctrl           i_ctrl,
    input  logic [lpps_pkg::DVD_W-1:0]    i_dividend,
    input  logic [lpps_pkg::SUM_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [lpps_pkg::Q_BITS-1:0]   o_quot
);
    import lpps_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DVD_W-1:0]   r_rem;
    logic [DVS_W-1:0]   r_dvs;
    logic [Q_BITS-1:0]  r_quot;
    logic               n_ge;

    // restoring step: one quotient bit per cycle, msb first
    assign n_ge = {{(DVS_W-DVD_W){1'b0}}, r_rem} >= r_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_dividend;
                r_dvs  <= {i_divisor, {(Q_BITS-1){1'b0}}};
                r_quot <= '0;
            end else if (r_busy) begin
                if (n_ge) begin
                    r_rem <= r_rem - r_dvs[DVD_W-1:0];
                end
                r_quot <= {r_quot[Q_BITS-2:0], n_ge};
                r_dvs  <= r_dvs >> 1;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_BITS-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ hdl/lpps_mac.sv @@
module lpps_mac (
    input  logic                                i_clk,
    input  lpps_pkg::t_mac_ctrl                 i_ctrl,
    input  logic signed [lpps_pkg::DIFF_W-1:0]  i_opa,
    input  logic [lpps_pkg::GAIN_W-1:0]         i_opb,
    output logic signed [lpps_pkg::ACC_W-1:0]   o_acc
);
    import lpps_pkg::*;

    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0]  r_acc;

    // gains are unsigned, widen with a zero sign bit
    assign n_prod = PROD_W'(i_opa * $signed({1'b0, i_opb}));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            if (i_ctrl.clear) begin
                r_acc <= ACC_W'(n_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(n_prod);
            end
        end
    end

    assign o_acc = r_acc;

endmodule

@@ hdl/line_position_pid_steering_unit.sv @@
// line position pid steering unit
// input channel: i_in_valid / o_in_ready carry one transfer of four reflectance
// samples (sample_a weighted +3 .. sample_d weighted -3)
// output channel: o_out_valid / i_out_ready carry one transfer of left and right
// motor drive per input transfer, in 1/256 units
// config: i_cfg_wr_en writes i_cfg_data into register i_cfg_index at once;
// the user must write only while the unit is idle, the block does not enforce it
// sequence: one item is in work at a time, and o_in_ready goes high again together
// with o_out_valid as the result is loaded; an item passes the start step, the
// restoring divider (one quotient bit a cycle), three passes through the shared
// multiply accumulate, the rounding step and the output step in turn
// reset: registers return to their defaults, last error and integral clear,
// the output register empties
// stall: a finished result sits in the output register until taken; a new input
// is accepted meanwhile, and its own result waits in the last step until the
// output register is free
module line_position_pid_steering_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lpps_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lpps_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_wr_en,
    input  logic [lpps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lpps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lpps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_DIV, S_MP, S_MI, S_MD, S_RND, S_OUT
    } t_state;

    t_state r_state;

    // config registers
    logic [GAIN_W-1:0]  r_prop_gain;
    logic [GAIN_W-1:0]  r_integ_gain;
    logic [GAIN_W-1:0]  r_deriv_gain;
    logic [SPEED_W-1:0] r_base_speed;
    logic [LIMIT_W-1:0] r_integ_limit;
    logic [BIAS_W-1:0]  r_turn_bias;
    logic [OFFS_W-1:0]  r_lost_offset;
    logic [THR_W-1:0]   r_dark_thr;

    // loop state and working registers
    logic signed [ERR_W-1:0]  r_last;
    logic signed [ERR_W-1:0]  r_integ;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [WSUM_W-1:0] r_wsum;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_lost;
    logic signed [CORR_W-1:0] r_corr;
    logic                     r_out_valid;
    t_out_item                r_out_item;

    // sensor combine at the input transfer
    logic signed [WSUM_W-1:0] n_sa, n_sb, n_sc, n_sd, n_wsum;
    logic [SUM_W-1:0]         n_sum;
    logic                     n_lost;
    logic                     n_in_xfer;

    assign n_in_xfer = i_in_valid && o_in_ready;
    assign n_sa = $signed({{(WSUM_W-SAMPLE_BITS){1'b0}}, i_in_item.sample_a});
    assign n_sb = $signed({{(WSUM_W-SAMPLE_BITS){1'b0}}, i_in_item.sample_b});
    assign n_sc = $signed({{(WSUM_W-SAMPLE_BITS){1'b0}}, i_in_item.sample_c});
    assign n_sd = $signed({{(WSUM_W-SAMPLE_BITS){1'b0}}, i_in_item.sample_d});
    // weights +3 +1 -1 -3
    assign n_wsum = (n_sa <<< 1) + n_sa + n_sb - n_sc - (n_sd <<< 1) - n_sd;
    assign n_sum  = {2'b00, i_in_item.sample_a} + {2'b00, i_in_item.sample_b}
                  + {2'b00, i_in_item.sample_c} + {2'b00, i_in_item.sample_d};
    assign n_lost = (i_in_item.sample_a >= r_dark_thr) && (i_in_item.sample_b >= r_dark_thr)
                 && (i_in_item.sample_c >= r_dark_thr) && (i_in_item.sample_d >= r_dark_thr);

    // divider: |wsum| * 256 / sum
    t_div_ctrl                n_div_ctrl;
    logic [WSUM_W-1:0]        n_wneg;
    logic [SUM_W-1:0]         n_mag;
    logic                     n_div_done;
    logic [Q_BITS-1:0]        n_quot;

    assign n_wneg = -r_wsum;
    assign n_mag  = r_wsum[WSUM_W-1] ? n_wneg[SUM_W-1:0] : r_wsum[SUM_W-1:0];
    assign n_div_ctrl.start = (r_state == S_START);

    lpps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (n_div_ctrl),
        .i_dividend ({n_mag, {POS_FRAC{1'b0}}}),
        .i_divisor  (r_sum),
        .o_done     (n_div_done),
        .o_quot     (n_quot)
    );

    // error, integral and difference once the quotient is in
    logic signed [ERR_W-1:0]  n_err;
    logic signed [ERR_W-1:0]  n_offs;
    logic signed [ERR_W-1:0]  n_qpos;
    logic signed [DIFF_W-1:0] n_isum;
    logic signed [DIFF_W-1:0] n_lim;
    logic signed [ERR_W-1:0]  n_integ;
    logic signed [DIFF_W-1:0] n_diff;

    assign n_offs = $signed({1'b0, r_lost_offset});
    assign n_qpos = $signed({1'b0, n_quot});

    always_comb begin
        // a lost line wins over a zero sum
        if (r_lost) begin
            n_err = (r_last > $signed(ERR_W'(0))) ? n_offs : -n_offs;
        end else if (r_sum == '0) begin
            n_err = '0;
        end else begin
            n_err = r_wsum[WSUM_W-1] ? -n_qpos : n_qpos;
        end
    end

    assign n_isum = {n_err[ERR_W-1], n_err} + {r_integ[ERR_W-1], r_integ};
    assign n_lim  = $signed({2'b00, r_integ_limit});
    assign n_diff = {n_err[ERR_W-1], n_err} - {r_last[ERR_W-1], r_last};

    always_comb begin
        if (n_isum > n_lim) begin
            n_integ = n_lim[ERR_W-1:0];
        end else if (n_isum < -n_lim) begin
            n_integ = ERR_W'(-n_lim);
        end else begin
            n_integ = n_isum[ERR_W-1:0];
        end
    end

    // shared multiply accumulate: prop, integ, deriv terms in turn
    t_mac_ctrl                n_mac_ctrl;
    logic signed [DIFF_W-1:0] n_opa;
    logic [GAIN_W-1:0]        n_opb;
    logic signed [ACC_W-1:0]  n_acc;

    always_comb begin
        n_mac_ctrl.en    = 1'b0;
        n_mac_ctrl.clear = 1'b0;
        n_opa            = {r_err[ERR_W-1], r_err};
        n_opb            = r_prop_gain;
        unique case (r_state)
            S_MP: begin
                n_mac_ctrl.en    = 1'b1;
                n_mac_ctrl.clear = 1'b1;
            end
            S_MI: begin
                n_mac_ctrl.en = 1'b1;
                n_opa         = {r_integ[ERR_W-1], r_integ};
                n_opb         = r_integ_gain;
            end
            S_MD: begin
                n_mac_ctrl.en = 1'b1;
                n_opa         = r_diff;
                n_opb         = r_deriv_gain;
            end
            default: begin
            end
        endcase
    end

    lpps_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (n_mac_ctrl),
        .i_opa  (n_opa),
        .i_opb  (n_opb),
        .o_acc  (n_acc)
    );

    // round to nearest, ties away from zero
    logic [ACC_W-1:0]         n_amag;
    logic [ACC_W-1:0]         n_rnd;
    logic signed [CORR_W-1:0] n_cmag;
    logic signed [CORR_W-1:0] n_corr;

    assign n_amag = n_acc[ACC_W-1] ? ACC_W'(-n_acc) : ACC_W'(n_acc);
    assign n_rnd  = n_amag + ACC_W'(ROUND_HALF);
    assign n_cmag = $signed(n_rnd[POS_FRAC +: CORR_W]);
    assign n_corr = n_acc[ACC_W-1] ? -n_cmag : n_cmag;

    // drives: clamp, then bias one way or the other
    logic signed [DSUM_W-1:0] n_base;
    logic signed [DSUM_W-1:0] n_rsum, n_lsum;
    logic [DRIVE_W-1:0]       n_rclamp, n_lclamp;
    logic [DRIVE_W-1:0]       n_bias;
    t_out_item                n_out_item;

    assign n_base = $signed({{(DSUM_W-SPEED_W){1'b0}}, r_base_speed});
    assign n_rsum = n_base + {r_corr[CORR_W-1], r_corr};
    assign n_lsum = n_base - {r_corr[CORR_W-1], r_corr};
    assign n_bias = {{(DRIVE_W-BIAS_W){1'b0}}, r_turn_bias};

    always_comb begin
        if (n_rsum < $signed(DSUM_W'(DRIVE_MIN))) begin
            n_rclamp = DRIVE_W'(DRIVE_MIN);
        end else if (n_rsum > $signed(DSUM_W'(DRIVE_MAX))) begin
            n_rclamp = DRIVE_W'(DRIVE_MAX);
        end else begin
            n_rclamp = n_rsum[DRIVE_W-1:0];
        end
        if (n_lsum < $signed(DSUM_W'(DRIVE_MIN))) begin
            n_lclamp = DRIVE_W'(DRIVE_MIN);
        end else if (n_lsum > $signed(DSUM_W'(DRIVE_MAX))) begin
            n_lclamp = DRIVE_W'(DRIVE_MAX);
        end else begin
            n_lclamp = n_lsum[DRIVE_W-1:0];
        end
        // error above 0.05 turns one way, anything else the other
        if (r_err >= $signed(ERR_W'(BIAS_SPLIT))) begin
            n_out_item.left_drive  = n_lclamp + n_bias;
            n_out_item.right_drive = n_rclamp - n_bias;
        end else begin
            n_out_item.left_drive  = n_lclamp - n_bias;
            n_out_item.right_drive = n_rclamp + n_bias;
        end
    end

    // output register frees when taken
    logic n_out_free;
    assign n_out_free = !r_out_valid || i_out_ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= RST_PROP_GAIN;
            r_integ_gain  <= RST_INTEG_GAIN;
            r_deriv_gain  <= RST_DERIV_GAIN;
            r_base_speed  <= RST_BASE_SPEED;
            r_integ_limit <= RST_INTEG_LIMIT;
            r_turn_bias   <= RST_TURN_BIAS;
            r_lost_offset <= RST_LOST_OFFSET;
            r_dark_thr    <= RST_DARK_THR;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_BASE_SPEED:  r_base_speed  <= i_cfg_data[SPEED_W-1:0];
                CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_TURN_BIAS:   r_turn_bias   <= i_cfg_data[BIAS_W-1:0];
                CFG_LOST_OFFSET: r_lost_offset <= i_cfg_data[OFFS_W-1:0];
                CFG_DARK_THR:    r_dark_thr    <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result loads, otherwise a taken result empties the register
            if (r_state == S_OUT && n_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_in_xfer) begin
                        r_wsum  <= n_wsum;
                        r_sum   <= n_sum;
                        r_lost  <= n_lost;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (n_div_done) begin
                        r_err   <= n_err;
                        r_diff  <= n_diff;
                        r_integ <= n_integ;
                        r_last  <= n_err;
                        r_state <= S_MP;
                    end
                end
                S_MP: begin
                    r_state <= S_MI;
                end
                S_MI: begin
                    r_state <= S_MD;
                end
                S_MD: begin
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_corr  <= n_corr;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold here while the previous result is still unread
                    if (n_out_free) begin
                        r_out_item <= n_out_item;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ hdl/lpps_checker.sv @@
module lpps_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  lpps_pkg::t_out_item                 o_out_item
);
    import lpps_pkg::*;

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed or dropped while stalled");

    // one item in work at a time
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an input transfer");

    // no result can appear right after an input transfer into an empty output
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared one cycle after input transfer");

    // clamp plus bias keeps both drives in range
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_item.left_drive >= DRIVE_W'(OUT_MIN))
            && (o_out_item.left_drive <= DRIVE_W'(OUT_MAX))
            && (o_out_item.right_drive >= DRIVE_W'(OUT_MIN))
            && (o_out_item.right_drive <= DRIVE_W'(OUT_MAX)))
        else $error("drive out of range");

endmodule

bind line_position_pid_steering_unit lpps_checker u_lpps_checker (.*);
